// ----- hdl/mq_pkg.sv -----
// mq_pkg: shared sizes, codes and the step result type of the message ring queue
// no dependencies; used by mq_store, mq_ctrl and fixed_size_message_ring_queue
package mq_pkg;

  localparam int unsigned MAX_MESSAGES      = 16;
  localparam int unsigned MAX_MESSAGE_BYTES = 192;
  localparam int unsigned STORE_DEPTH       = MAX_MESSAGES * MAX_MESSAGE_BYTES;

  localparam int unsigned SLOT_W  = $clog2(MAX_MESSAGES);
  localparam int unsigned OFS_W   = 8;
  localparam int unsigned DEPTH_W = 5;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned ADDR_W  = $clog2(STORE_DEPTH);
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_MESSAGES);
  localparam logic [OFS_W-1:0]   BYTES_MAX = OFS_W'(MAX_MESSAGE_BYTES);

  // item kinds
  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_GET = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_DEPTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_BYTES = 1'b1;

  typedef struct packed {
    logic             rd_ok;
    logic             last;
    logic             status;
    logic [CNT_W-1:0] count;
  } step_t;

endpackage

// ----- hdl/mq_store.sv -----
// mq_store: byte-wide message store, one access per cycle, registered read data
// depends on mq_pkg for its size
module mq_store (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic                        re_i,
  input  logic [mq_pkg::ADDR_W-1:0]   addr_i,
  input  logic [mq_pkg::DATA_W-1:0]   wdata_i,
  output logic [mq_pkg::DATA_W-1:0]   rdata_o
);

  logic [mq_pkg::DATA_W-1:0] mem_q [mq_pkg::STORE_DEPTH];
  logic [mq_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/mq_ctrl.sv -----
// mq_ctrl: registers, slot pointers, byte offsets and count; store address and access
// depends on mq_pkg
module mq_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          kind_i,
  input  logic                          cfg_we_i,
  input  logic [mq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mq_pkg::CFG_W-1:0]      cfg_data_i,
  output logic                          mem_we_o,
  output logic                          mem_re_o,
  output logic [mq_pkg::ADDR_W-1:0]     mem_addr_o,
  output mq_pkg::step_t                 step_o
);

  logic [mq_pkg::DEPTH_W-1:0] depth_q, depth_d;
  logic [mq_pkg::OFS_W-1:0]   mb_q, mb_d;
  logic [mq_pkg::SLOT_W-1:0]  wslot_q, wslot_d, rslot_q, rslot_d;
  logic [mq_pkg::OFS_W-1:0]   wofs_q, wofs_d, rofs_q, rofs_d;
  logic [mq_pkg::CNT_W-1:0]   held_q, held_d;

  logic                       is_get, put_rej, get_rej, put_ok, get_ok;
  logic                       w_end, r_end;
  logic [mq_pkg::OFS_W-1:0]   wofs_inc, rofs_inc;
  logic [mq_pkg::SLOT_W-1:0]  wslot_inc, rslot_inc, slot_sel;
  logic [mq_pkg::OFS_W-1:0]   ofs_sel;
  logic [mq_pkg::ADDR_W-1:0]  base;
  logic [mq_pkg::DEPTH_W-1:0] qd_val;
  logic [mq_pkg::OFS_W-1:0]   mb_val;
  logic                       clr;

  assign is_get  = (kind_i == mq_pkg::KIND_GET);
  // only the first byte of a message checks full / empty
  assign put_rej = (wofs_q == '0) && (held_q >= depth_q);
  assign get_rej = (rofs_q == '0) && (held_q == '0);
  assign put_ok  = step_i && !is_get && !put_rej;
  assign get_ok  = step_i && is_get && !get_rej;

  assign wofs_inc  = wofs_q + 1'b1;
  assign rofs_inc  = rofs_q + 1'b1;
  assign w_end     = (wofs_inc == mb_q);
  assign r_end     = (rofs_inc == mb_q);
  assign wslot_inc = wslot_q + 1'b1;
  assign rslot_inc = rslot_q + 1'b1;

  assign slot_sel   = is_get ? rslot_q : wslot_q;
  assign ofs_sel    = is_get ? rofs_q : wofs_q;
  assign base       = mq_pkg::ADDR_W'(slot_sel) * mq_pkg::ADDR_W'(mb_q);
  assign mem_addr_o = base + mq_pkg::ADDR_W'(ofs_sel);
  assign mem_we_o   = put_ok;
  assign mem_re_o   = get_ok;

  assign qd_val = cfg_data_i[mq_pkg::DEPTH_W-1:0];
  assign mb_val = cfg_data_i[mq_pkg::OFS_W-1:0];

  always_comb begin
    depth_d = depth_q;
    mb_d    = mb_q;
    wslot_d = wslot_q;
    rslot_d = rslot_q;
    wofs_d  = wofs_q;
    rofs_d  = rofs_q;
    held_d  = held_q;
    clr     = 1'b0;

    if (put_ok) begin
      if (w_end) begin
        wofs_d  = '0;
        wslot_d = ({1'b0, wslot_inc} == depth_q) ? '0 : wslot_inc;
        held_d  = held_q + 1'b1;
      end else begin
        wofs_d = wofs_inc;
      end
    end
    if (get_ok) begin
      if (r_end) begin
        rofs_d  = '0;
        rslot_d = ({1'b0, rslot_inc} == depth_q) ? '0 : rslot_inc;
        if (held_q != '0) begin
          held_d = held_q - 1'b1;
        end
      end else begin
        rofs_d = rofs_inc;
      end
    end

    // a zero write is dropped, anything else clamps and clears the queue
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        mq_pkg::REG_QUEUE_DEPTH: begin
          if (qd_val != '0) begin
            depth_d = (qd_val > mq_pkg::DEPTH_MAX) ? mq_pkg::DEPTH_MAX : qd_val;
            clr     = 1'b1;
          end
        end
        mq_pkg::REG_MESSAGE_BYTES: begin
          if (mb_val != '0) begin
            mb_d = (mb_val > mq_pkg::BYTES_MAX) ? mq_pkg::BYTES_MAX : mb_val;
            clr  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (clr) begin
      wslot_d = '0;
      rslot_d = '0;
      wofs_d  = '0;
      rofs_d  = '0;
      held_d  = '0;
    end
  end

  always_comb begin
    step_o.rd_ok  = get_ok;
    step_o.last   = (put_ok && w_end) || (get_ok && r_end);
    step_o.status = is_get ? get_rej : put_rej;
    step_o.count  = held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= mq_pkg::DEPTH_MAX;
      mb_q    <= mq_pkg::BYTES_MAX;
      wslot_q <= '0;
      rslot_q <= '0;
      wofs_q  <= '0;
      rofs_q  <= '0;
      held_q  <= '0;
    end else begin
      depth_q <= depth_d;
      mb_q    <= mb_d;
      wslot_q <= wslot_d;
      rslot_q <= rslot_d;
      wofs_q  <= wofs_d;
      rofs_q  <= rofs_d;
      held_q  <= held_d;
    end
  end

`ifndef SYNTHESIS
  a_held_le_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= depth_q)
    else $error("held count above queue depth");

  a_slots_in_ring : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, wslot_q} < depth_q) && ({1'b0, rslot_q} < depth_q))
    else $error("slot pointer outside ring");

  a_ofs_in_msg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wofs_q < mb_q) && (rofs_q < mb_q))
    else $error("byte offset outside message");

  a_one_access : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("store read and write in one cycle");

  a_commit_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (put_ok && w_end && !cfg_we_i) |=> (held_q == $past(held_q) + 1'b1))
    else $error("commit did not raise count");
`endif

endmodule

// ----- hdl/fixed_size_message_ring_queue.sv -----
// fixed_size_message_ring_queue: top level, handshakes and result register
// depends on mq_pkg, mq_store and mq_ctrl
//
//  channel   signals                                   direction
//  in        in_valid_i/in_ready_o, kind_i, data_in_i   byte put or get request
//  out       out_valid_o/out_ready_i, data_out_o,       one result per request
//            last_byte_o, status_o, message_count_o
//  cfg       cfg_we_i, cfg_index_i, cfg_data_i          register write, no wait
//
// result and store read data are registered, out in the cycle after the request is taken
// a new request is taken in the cycle its predecessor's result leaves, so while out_ready_i
// is high one beat per cycle; while it is low a held result stays, in_ready_o drops with it
// reset loads depth 16 and 192 bytes per message and empties the queue; the store
// keeps its contents and needs no clearing pass
module fixed_size_message_ring_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [7:0]                    data_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    data_out_o,
  output logic                          last_byte_o,
  output logic                          status_o,
  output logic [4:0]                    message_count_o,
  input  logic                          cfg_we_i,
  input  logic [mq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mq_pkg::CFG_W-1:0]      cfg_data_i
);

  logic                          step;
  logic                          mem_we, mem_re;
  logic [mq_pkg::ADDR_W-1:0]     mem_addr;
  logic [mq_pkg::DATA_W-1:0]     mem_rdata;
  mq_pkg::step_t                 res_d, res_q;
  logic                          valid_q, valid_d;

  assign in_ready_o = !valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  mq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .kind_i      (kind_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .step_o      (res_d)
  );

  mq_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (data_in_i),
    .rdata_o (mem_rdata)
  );

  assign valid_d = step || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  // store read data stays put until the next accepted get
  assign out_valid_o     = valid_q;
  assign data_out_o      = res_q.rd_ok ? mem_rdata : '0;
  assign last_byte_o     = res_q.last;
  assign status_o        = res_q.status;
  assign message_count_o = res_q.count;

`ifndef SYNTHESIS
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("accepted beat left no result");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !step)
    else $error("request taken over a stalled result");

  a_reject_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (data_out_o == '0 && !last_byte_o))
    else $error("rejected beat carries data");
`endif

endmodule

// ----- tb/fixed_size_message_ring_queue_tb.sv -----
`timescale 1ns / 1ps
// fixed_size_message_ring_queue_tb: self-checking bench with a queue predictor and scoreboard
// depends on mq_pkg and fixed_size_message_ring_queue

typedef struct packed {
  logic [mq_pkg::DATA_W-1:0] data;
  logic                      last;
  logic                      status;
  logic [mq_pkg::CNT_W-1:0]  count;
} queue_reply_t;

class queue_scoreboard;
  logic [mq_pkg::DATA_W-1:0]  store [mq_pkg::STORE_DEPTH];
  logic [mq_pkg::DEPTH_W-1:0] depth;
  logic [mq_pkg::OFS_W-1:0]   msg_bytes;
  logic [mq_pkg::SLOT_W-1:0]  rd_slot;
  logic [mq_pkg::SLOT_W-1:0]  wr_slot;
  logic [mq_pkg::CNT_W-1:0]   held;
  logic [mq_pkg::OFS_W-1:0]   wr_ofs;
  logic [mq_pkg::OFS_W-1:0]   rd_ofs;
  queue_reply_t               replies_due[$];
  int unsigned                errors;

  function new();
    depth     = mq_pkg::DEPTH_MAX;
    msg_bytes = mq_pkg::BYTES_MAX;
    errors    = 0;
    clear_ptrs();
  endfunction

  function void clear_ptrs();
    rd_slot = '0;
    wr_slot = '0;
    held    = '0;
    wr_ofs  = '0;
    rd_ofs  = '0;
  endfunction

  function void apply_reg(input logic [mq_pkg::CFG_IDX_W-1:0] idx,
                          input logic [mq_pkg::CFG_W-1:0] value);
    logic [mq_pkg::DEPTH_W-1:0] slots;
    slots = value[mq_pkg::DEPTH_W-1:0];
    // zero writes leave everything alone, the rest clamp and empty the queue
    if (idx == mq_pkg::REG_QUEUE_DEPTH) begin
      if (slots != '0) begin
        depth = (slots > mq_pkg::DEPTH_MAX) ? mq_pkg::DEPTH_MAX : slots;
        clear_ptrs();
      end
    end else if (idx == mq_pkg::REG_MESSAGE_BYTES) begin
      if (value != '0) begin
        msg_bytes = (value > mq_pkg::BYTES_MAX) ? mq_pkg::BYTES_MAX : value;
        clear_ptrs();
      end
    end
  endfunction

  function bit put_blocked();
    return (wr_ofs == '0) && (held >= depth);
  endfunction

  function bit get_blocked();
    return (rd_ofs == '0) && (held == '0);
  endfunction

  function int unsigned pending();
    return replies_due.size();
  endfunction

  function int byte_addr(input logic [mq_pkg::SLOT_W-1:0] slot,
                         input logic [mq_pkg::OFS_W-1:0] ofs);
    return int'(slot) * int'(msg_bytes) + int'(ofs);
  endfunction

  function logic [mq_pkg::SLOT_W-1:0] next_slot(input logic [mq_pkg::SLOT_W-1:0] slot);
    if (int'(slot) + 1 >= int'(depth)) return '0;
    return slot + 1'b1;
  endfunction

  function void note_beat(input logic kind, input logic [mq_pkg::DATA_W-1:0] value);
    queue_reply_t r;
    r = '0;
    if (kind == mq_pkg::KIND_PUT) begin
      if (put_blocked()) begin
        r.status = 1'b1;
      end else begin
        store[byte_addr(wr_slot, wr_ofs)] = value;
        wr_ofs = wr_ofs + 1'b1;
        if (wr_ofs >= msg_bytes) begin
          wr_ofs  = '0;
          wr_slot = next_slot(wr_slot);
          held    = held + 1'b1;
          r.last  = 1'b1;
        end
      end
    end else begin
      if (get_blocked()) begin
        r.status = 1'b1;
      end else begin
        r.data = store[byte_addr(rd_slot, rd_ofs)];
        rd_ofs = rd_ofs + 1'b1;
        if (rd_ofs >= msg_bytes) begin
          rd_ofs  = '0;
          rd_slot = next_slot(rd_slot);
          if (held != '0) held = held - 1'b1;
          r.last  = 1'b1;
        end
      end
    end
    r.count = held;
    replies_due.push_back(r);
  endfunction

  task report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("ERROR at %0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  task check_result(input logic [mq_pkg::DATA_W-1:0] data, input logic last,
                    input logic status, input logic [mq_pkg::CNT_W-1:0] count);
    queue_reply_t want;
    if (replies_due.size() == 0) begin
      report("result beat with no request outstanding", {data, last, status, count}, 0);
      return;
    end
    want = replies_due.pop_front();
    if (data !== want.data) report("data_out", data, want.data);
    if (last !== want.last) report("last_byte", last, want.last);
    if (status !== want.status) report("status", status, want.status);
    if (count !== want.count) report("message_count", count, want.count);
  endtask
endclass

module fixed_size_message_ring_queue_tb;

  localparam int unsigned HOLD_CYCLES = 300;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  logic                         kind_i      = mq_pkg::KIND_PUT;
  logic [7:0]                   data_in_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [7:0]                   data_out_o;
  logic                         last_byte_o;
  logic                         status_o;
  logic [4:0]                   message_count_o;
  logic                         cfg_we_i    = 1'b0;
  logic [mq_pkg::CFG_IDX_W-1:0] cfg_index_i = mq_pkg::REG_QUEUE_DEPTH;
  logic [mq_pkg::CFG_W-1:0]     cfg_data_i  = '0;

  queue_scoreboard sb = new();
  bit              hold_off_req = 1'b0;
  int unsigned     burst_left   = 0;
  int unsigned     beats_sent   = 0;

  fixed_size_message_ring_queue DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .data_in_i      (data_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_out_o     (data_out_o),
    .last_byte_o    (last_byte_o),
    .status_o       (status_o),
    .message_count_o(message_count_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // offer one beat, with bursts and gaps on the sender side
  task automatic send_beat(input logic kind, input logic [7:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    data_in_i  <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_beat(kind, value);
    beats_sent++;
  endtask

  // wait until every result is back and the block is quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mq_pkg::CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    sb.apply_reg(idx, value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly whole messages in fill and drain stretches, some lone beats
  task automatic run_phase(input int unsigned budget);
    int unsigned first_beat, stretch, n;
    bit          filling;
    logic        kind;
    first_beat = beats_sent;
    stretch    = 0;
    filling    = 1'b0;
    while (beats_sent - first_beat < budget) begin
      if (stretch == 0) begin
        filling = !filling;
        stretch = $urandom_range(3, 24);
      end
      stretch--;
      if (filling) kind = ($urandom_range(0, 3) == 0) ? mq_pkg::KIND_GET : mq_pkg::KIND_PUT;
      else kind = ($urandom_range(0, 3) == 0) ? mq_pkg::KIND_PUT : mq_pkg::KIND_GET;
      if ($urandom_range(0, 9) == 0) n = 1;
      else if (kind == mq_pkg::KIND_PUT) n = sb.put_blocked() ? 1 : sb.msg_bytes - sb.wr_ofs;
      else n = sb.get_blocked() ? 1 : sb.msg_bytes - sb.rd_ofs;
      repeat (n) send_beat(kind, 8'($urandom_range(0, 255)));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(data_out_o, last_byte_o, status_o, message_count_o);
  end

  initial begin : receiver
    int unsigned mode, mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        // long hold-off so the result register backs up into the input
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0: begin
            out_ready_i <= 1'b1;
          end
          1: begin
            out_ready_i <= ($urandom_range(0, 1) == 1);
          end
          default: begin
            out_ready_i <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned guard;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: get on empty, then a partial message dropped by a register write
    send_beat(mq_pkg::KIND_GET, 8'h3C);
    send_beat(mq_pkg::KIND_PUT, 8'hFF);
    send_beat(mq_pkg::KIND_PUT, 8'h00);
    send_beat(mq_pkg::KIND_GET, 8'h00);
    settle();
    write_reg(mq_pkg::REG_QUEUE_DEPTH, 8'd1);
    write_reg(mq_pkg::REG_MESSAGE_BYTES, 8'd1);
    send_beat(mq_pkg::KIND_PUT, 8'hA5);
    send_beat(mq_pkg::KIND_PUT, 8'h5A);
    send_beat(mq_pkg::KIND_GET, 8'hFF);
    send_beat(mq_pkg::KIND_GET, 8'h00);
    settle();
    // two slots of two bytes: interleaved halves, full reject, slot wrap
    write_reg(mq_pkg::REG_QUEUE_DEPTH, 8'd2);
    write_reg(mq_pkg::REG_MESSAGE_BYTES, 8'd2);
    send_beat(mq_pkg::KIND_PUT, 8'h01);
    send_beat(mq_pkg::KIND_PUT, 8'h80);
    send_beat(mq_pkg::KIND_GET, 8'h00);
    send_beat(mq_pkg::KIND_PUT, 8'h7F);
    send_beat(mq_pkg::KIND_PUT, 8'hFE);
    send_beat(mq_pkg::KIND_PUT, 8'h11);
    send_beat(mq_pkg::KIND_GET, 8'h00);
    send_beat(mq_pkg::KIND_GET, 8'h00);
    send_beat(mq_pkg::KIND_GET, 8'h00);
    send_beat(mq_pkg::KIND_GET, 8'h00);

    settle();
    write_reg(mq_pkg::REG_QUEUE_DEPTH, 8'd3);
    write_reg(mq_pkg::REG_MESSAGE_BYTES, 8'd5);
    hold_off_req = 1'b1;
    run_phase(70);

    settle();
    write_reg(mq_pkg::REG_QUEUE_DEPTH, 8'd31);
    write_reg(mq_pkg::REG_MESSAGE_BYTES, 8'd1);
    run_phase(70);

    settle();
    write_reg(mq_pkg::REG_QUEUE_DEPTH, 8'd7);
    write_reg(mq_pkg::REG_MESSAGE_BYTES, 8'd3);
    run_phase(70);

    // only the low five bits count for the depth; oversized byte count clamps
    settle();
    write_reg(mq_pkg::REG_QUEUE_DEPTH, 8'h21);
    write_reg(mq_pkg::REG_MESSAGE_BYTES, 8'hFF);
    run_phase(300);

    settle();
    write_reg(mq_pkg::REG_QUEUE_DEPTH, 8'd28);
    write_reg(mq_pkg::REG_MESSAGE_BYTES, 8'd4);
    run_phase(60);
    // writes of zero must keep the queue and any half-done message
    settle();
    write_reg(mq_pkg::REG_QUEUE_DEPTH, 8'hE0);
    write_reg(mq_pkg::REG_MESSAGE_BYTES, 8'h00);
    run_phase(40);

    settle();
    write_reg(mq_pkg::REG_QUEUE_DEPTH, 8'd2);
    write_reg(mq_pkg::REG_MESSAGE_BYTES, 8'd2);
    run_phase(50);

    in_valid_i <= 1'b0;
    for (guard = 0; guard < 10000 && sb.pending() != 0; guard++) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("results never returned", sb.pending(), 0);
    if (sb.errors == 0) begin
      $display("fixed_size_message_ring_queue: match");
    end else begin
      $display("fixed_size_message_ring_queue: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("fixed_size_message_ring_queue: mismatch");
    $finish;
  end

endmodule
